/* design/lmsf_pkg.sv */
// Shared types and constants for the lamp mode / sleep fade controller.
`default_nettype none

package lmsf_pkg;

    localparam int unsigned CMD_W     = 3;
    localparam int unsigned DIM_W     = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned CNT10_W   = 10;
    localparam int unsigned IDLE_W    = 16;
    localparam int unsigned SLEEP_W   = 32;

    localparam logic [CNT10_W-1:0] CNT10_MAX = 10'd1023;

    // Reset values of the configuration registers
    localparam logic [IDLE_W-1:0]  IDLE_TIMEOUT_RST   = 16'd200;
    localparam logic [SLEEP_W-1:0] SLEEP_DURATION_RST = 32'd1000000;
    localparam logic [CNT10_W-1:0] BEACON_INT_RST     = 10'd500;
    localparam logic [CNT10_W-1:0] ADDR_RETRY_RST     = 10'd500;

    typedef enum logic [2:0] {
        MODE_RUNNING       = 3'd0,
        MODE_PAUSE         = 3'd1,
        MODE_ENTER_STANDBY = 3'd2,
        MODE_STANDBY       = 3'd3,
        MODE_LEAVE_STANDBY = 3'd4,
        MODE_ENTER_SLEEP   = 3'd5,
        MODE_SLEEP         = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        CMD_TICK          = 3'd0,
        CMD_TOUCH         = 3'd1,
        CMD_STANDBY       = 3'd2,
        CMD_LEAVE_STANDBY = 3'd3,
        CMD_SLEEP         = 3'd4,
        CMD_ADDR_ASSIGNED = 3'd5,
        CMD_SET_DIM       = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        SEND_NONE     = 2'd0,
        SEND_BEACON   = 2'd1,
        SEND_QUERY    = 2'd2,
        SEND_ANNOUNCE = 2'd3
    } send_t;

    typedef enum logic [2:0] {
        CFG_IDLE_TIMEOUT   = 3'd0,
        CFG_SLEEP_DURATION = 3'd1,
        CFG_IS_SLAVE       = 3'd2,
        CFG_HAS_IDENTITY   = 3'd3,
        CFG_BEACON_INT     = 3'd4,
        CFG_ADDR_RETRY     = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EXEC = 2'd2
    } ctl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic latch;
        logic div_start;
        logic commit;
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/lmsf_div.sv */
// Iterative restoring divider, 32-bit dividend by 8-bit divisor, one bit a cycle.
`default_nettype none

module lmsf_div
    import lmsf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SLEEP_W-1:0] dividend,
    input  wire logic [DIM_W-1:0]   divisor,
    output logic                    done,
    output logic [SLEEP_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(SLEEP_W);

    logic               busy_reg,    busy_next;
    logic               done_reg,    done_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [DIM_W-1:0]   rem_reg,     rem_next;
    logic [SLEEP_W-1:0] quo_reg,     quo_next;
    logic [DIM_W-1:0]   dvs_reg,     dvs_next;
    logic [DIM_W:0]     trial;
    logic [DIM_W:0]     diff;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SLEEP_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_next = {quo_reg[SLEEP_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SLEEP_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* design/lmsf_dp.sv */
// Datapath: configuration, mode state, slave counters, result register.
`default_nettype none

module lmsf_dp
    import lmsf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [DIM_W-1:0]     dim_value,
    input  wire logic                 send_ok,
    input  wire ctl_cmd_t             ctl,
    output dp_stat_t                  stat,
    output logic [2:0]                mode_code,
    output logic                      running,
    output logic [DIM_W-1:0]          dim_level,
    output logic [1:0]                send_kind,
    output logic                      address_clear
);

    // configuration
    logic [IDLE_W-1:0]  idle_timeout_reg;
    logic [SLEEP_W-1:0] sleep_duration_reg;
    logic               is_slave_reg;
    logic               has_identity_reg;
    logic [CNT10_W-1:0] beacon_int_reg;
    logic [CNT10_W-1:0] addr_retry_reg;

    // latched command beat
    logic [CMD_W-1:0]   item_cmd_reg;
    logic [DIM_W-1:0]   item_dim_reg;
    logic               item_ok_reg;

    // controller state
    mode_t              mode_reg,        mode_next;
    mode_t              saved_mode_reg,  saved_mode_next;
    logic [DIM_W-1:0]   dim_reg,         dim_next;
    logic [DIM_W-1:0]   saved_dim_reg,   saved_dim_next;
    logic               run_reg,         run_next;
    logic [SLEEP_W-1:0] sleep_count_reg, sleep_count_next;
    logic [SLEEP_W-1:0] sleep_step_reg,  sleep_step_next;
    logic [IDLE_W-1:0]  idle_count_reg,  idle_count_next;
    logic [CNT10_W-1:0] phase_reg,       phase_next;
    logic [CNT10_W-1:0] beacon_reg,      beacon_next;

    // result register
    mode_t              out_mode_reg;
    logic               out_run_reg;
    logic [DIM_W-1:0]   out_dim_reg;
    send_t              out_kind_reg;
    logic               out_clr_reg;

    send_t              kind;
    logic               clr;
    logic               in_standby_group;
    logic [SLEEP_W-1:0] sleep_inc;
    logic [DIM_W-1:0]   dim_dec;
    logic [CNT10_W-1:0] phase_mid;
    logic [SLEEP_W-1:0] quotient;
    logic               div_done;

    lmsf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (sleep_duration_reg),
        .divisor  (dim_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Only a tick arriving in enter-sleep with a non-zero dim needs the divider
    always_comb
    begin
        stat.need_div = (command == CMD_TICK) && (mode_reg == MODE_ENTER_SLEEP)
                        && (dim_reg != '0);
        stat.div_done = div_done;
    end

    always_comb
    begin
        in_standby_group = mode_reg inside {MODE_ENTER_STANDBY, MODE_STANDBY,
                                            MODE_LEAVE_STANDBY};
        mode_next        = mode_reg;
        saved_mode_next  = saved_mode_reg;
        dim_next         = dim_reg;
        saved_dim_next   = saved_dim_reg;
        run_next         = run_reg;
        sleep_count_next = sleep_count_reg;
        sleep_step_next  = sleep_step_reg;
        idle_count_next  = idle_count_reg;
        phase_next       = phase_reg;
        beacon_next      = beacon_reg;
        kind             = SEND_NONE;
        clr              = 1'b0;
        sleep_inc        = sleep_count_reg + 32'd1;
        dim_dec          = (dim_reg != '0) ? dim_reg - 8'd1 : '0;
        phase_mid        = phase_reg;

        case (item_cmd_reg)
            CMD_TICK:
            begin
                case (mode_reg)
                    MODE_RUNNING:
                    begin
                        run_next = 1'b1;
                    end
                    MODE_PAUSE:
                    begin
                        run_next = 1'b0;
                    end
                    MODE_ENTER_STANDBY:
                    begin
                        saved_dim_next = dim_reg;
                        dim_next       = '0;
                        run_next       = 1'b0;
                        mode_next      = MODE_STANDBY;
                    end
                    MODE_LEAVE_STANDBY:
                    begin
                        dim_next  = saved_dim_reg;
                        run_next  = 1'b1;
                        mode_next = saved_mode_reg;
                    end
                    MODE_ENTER_SLEEP:
                    begin
                        sleep_count_next = '0;
                        saved_dim_next   = dim_reg;
                        if (dim_reg == '0)
                        begin
                            mode_next = MODE_STANDBY;
                            run_next  = 1'b0;
                        end
                        else
                        begin
                            sleep_step_next = (quotient == '0) ? 32'd1 : quotient;
                            mode_next       = MODE_SLEEP;
                        end
                    end
                    MODE_SLEEP:
                    begin
                        if (sleep_inc >= sleep_step_reg)
                        begin
                            sleep_count_next = '0;
                            dim_next         = dim_dec;
                            if (dim_dec == '0)
                            begin
                                mode_next = MODE_STANDBY;
                                run_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            sleep_count_next = sleep_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (is_slave_reg)
                begin
                    // beacon once addressed
                    if (phase_reg == '0)
                    begin
                        if (beacon_reg < CNT10_MAX)
                        begin
                            beacon_next = beacon_reg + 10'd1;
                        end
                        if ((beacon_reg >= beacon_int_reg) && item_ok_reg)
                        begin
                            kind        = SEND_BEACON;
                            beacon_next = '0;
                        end
                    end
                    // address request
                    if (phase_reg == 10'd1)
                    begin
                        clr = 1'b1;
                        if (item_ok_reg)
                        begin
                            kind      = has_identity_reg ? SEND_ANNOUNCE : SEND_QUERY;
                            phase_mid = 10'd2;
                        end
                    end
                    // retry wait, runs in the same tick as a fresh request
                    phase_next = phase_mid;
                    if (phase_mid > 10'd1)
                    begin
                        if (phase_mid < CNT10_MAX)
                        begin
                            phase_next = phase_mid + 10'd1;
                        end
                        if ((phase_mid > addr_retry_reg) || (phase_mid == CNT10_MAX))
                        begin
                            phase_next = 10'd1;
                        end
                    end
                end

                if (idle_count_reg != '0)
                begin
                    idle_count_next = idle_count_reg - 16'd1;
                    if (idle_count_reg == 16'd1)
                    begin
                        mode_next = MODE_RUNNING;
                    end
                end
            end
            CMD_TOUCH:
            begin
                idle_count_next = idle_timeout_reg;
                mode_next       = MODE_PAUSE;
            end
            CMD_STANDBY:
            begin
                if (!in_standby_group)
                begin
                    saved_mode_next = mode_reg;
                    mode_next       = MODE_ENTER_STANDBY;
                end
            end
            CMD_LEAVE_STANDBY:
            begin
                if (mode_reg == MODE_STANDBY)
                begin
                    mode_next = MODE_LEAVE_STANDBY;
                end
            end
            CMD_SLEEP:
            begin
                if (!in_standby_group)
                begin
                    mode_next = MODE_ENTER_SLEEP;
                end
            end
            CMD_ADDR_ASSIGNED:
            begin
                phase_next = '0;
            end
            CMD_SET_DIM:
            begin
                dim_next = item_dim_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg   <= IDLE_TIMEOUT_RST;
            sleep_duration_reg <= SLEEP_DURATION_RST;
            is_slave_reg       <= 1'b1;
            has_identity_reg   <= 1'b0;
            beacon_int_reg     <= BEACON_INT_RST;
            addr_retry_reg     <= ADDR_RETRY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_TIMEOUT:   idle_timeout_reg   <= cfg_data[IDLE_W-1:0];
                CFG_SLEEP_DURATION: sleep_duration_reg <= cfg_data[SLEEP_W-1:0];
                CFG_IS_SLAVE:       is_slave_reg       <= cfg_data[0];
                CFG_HAS_IDENTITY:   has_identity_reg   <= cfg_data[0];
                CFG_BEACON_INT:     beacon_int_reg     <= cfg_data[CNT10_W-1:0];
                CFG_ADDR_RETRY:     addr_retry_reg     <= cfg_data[CNT10_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RUNNING;
            saved_mode_reg  <= MODE_RUNNING;
            dim_reg         <= 8'd255;
            saved_dim_reg   <= 8'd255;
            run_reg         <= 1'b0;
            sleep_count_reg <= '0;
            sleep_step_reg  <= '0;
            idle_count_reg  <= '0;
            phase_reg       <= 10'd1;
            beacon_reg      <= '0;
        end
        else if (ctl.commit)
        begin
            mode_reg        <= mode_next;
            saved_mode_reg  <= saved_mode_next;
            dim_reg         <= dim_next;
            saved_dim_reg   <= saved_dim_next;
            run_reg         <= run_next;
            sleep_count_reg <= sleep_count_next;
            sleep_step_reg  <= sleep_step_next;
            idle_count_reg  <= idle_count_next;
            phase_reg       <= phase_next;
            beacon_reg      <= beacon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_cmd_reg <= command;
            item_dim_reg <= dim_value;
            item_ok_reg  <= send_ok;
        end
        if (ctl.commit)
        begin
            out_mode_reg <= mode_next;
            out_run_reg  <= run_next;
            out_dim_reg  <= dim_next;
            out_kind_reg <= kind;
            out_clr_reg  <= clr;
        end
    end

    assign mode_code     = 3'(out_mode_reg);
    assign running       = out_run_reg;
    assign dim_level     = out_dim_reg;
    assign send_kind     = 2'(out_kind_reg);
    assign address_clear = out_clr_reg;

endmodule

`default_nettype wire

/* design/lmsf_ctrl.sv */
// Controller: sequences accept, divide, commit and the result handshake.
`default_nettype none

module lmsf_ctrl
    import lmsf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      ctl
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.need_div ? ST_DIV : ST_EXEC;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        ctl.latch     = (state_reg == ST_IDLE) && in_valid;
        ctl.div_start = (state_reg == ST_IDLE) && in_valid && stat.need_div;
        ctl.commit    = (state_reg == ST_EXEC) && slot_free;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* design/lamp_mode_sleep_fade_controller.sv */
// Top level of the lamp mode / sleep fade controller.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  config   | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[31:0]
//  command  | in_valid / in_ready   | command[2:0], dim_value[7:0], send_ok
//  result   | out_valid / out_ready | mode_code[2:0], running, dim_level[7:0],
//           |                       | send_kind[1:0], address_clear
//
// One command beat is worked at a time: accept, execute, then the
// result beat sits in the output register.
// A tick in enter-sleep with a non-zero dim runs the 32-by-8 serial
// divider first, one quotient bit a cycle, before the execute step.
// A new command beat is taken while the previous result still waits; a
// stalled result holds only the execute step of the next beat.
// Config is always ready. Reset is asynchronous, active low, and loads the
// register defaults (idle_timeout 200, sleep_duration 1000000, slave on).
`default_nettype none

module lamp_mode_sleep_fade_controller
    import lmsf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [DIM_W-1:0]     dim_value,
    input  wire logic                 send_ok,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                mode_code,
    output logic                      running,
    output logic [DIM_W-1:0]          dim_level,
    output logic [1:0]                send_kind,
    output logic                      address_clear
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lmsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    lmsf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .dim_value     (dim_value),
        .send_ok       (send_ok),
        .ctl           (ctl),
        .stat          (stat),
        .mode_code     (mode_code),
        .running       (running),
        .dim_level     (dim_level),
        .send_kind     (send_kind),
        .address_clear (address_clear)
    );

    // One beat in flight: accepting closes the input until the commit
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("command accepted while a beat was in flight");

    // A commit always presents a result beat
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid)
        else $error("commit without result beat");

    // The divider only finishes while the controller waits on it
    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> !in_ready)
        else $error("divider finished while controller idle");

    // No commit in the same cycle as an accept
    a_no_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> !in_ready)
        else $error("commit while idle");

endmodule

`default_nettype wire

/* tb/lamp_mode_sleep_fade_controller_test.sv */
// Self-checking testbench for the lamp mode / sleep fade controller.
module lamp_mode_sleep_fade_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lmsf_pkg::*;

    // Cycles with no beat on any channel before the run is abandoned. The
    // long receiver hold-off is HOLD_CYCLES.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] dim;
        logic       ok;
    } lamp_cmd_t;

    typedef struct packed {
        mode_t      mode;
        logic       run;
        logic [7:0] dim;
        send_t      kind;
        logic       clr;
    } lamp_status_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  command = '0;
    logic [7:0]  dim_value = '0;
    logic        send_ok = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  mode_code;
    logic        running;
    logic [7:0]  dim_level;
    logic [1:0]  send_kind;
    logic        address_clear;

    lamp_mode_sleep_fade_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .dim_value     (dim_value),
        .send_ok       (send_ok),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mode_code     (mode_code),
        .running       (running),
        .dim_level     (dim_level),
        .send_kind     (send_kind),
        .address_clear (address_clear)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the controller: config registers and mode state
    // ------------------------------------------------------------------
    logic [15:0] cf_idle_timeout   = IDLE_TIMEOUT_RST;
    logic [31:0] cf_sleep_duration = SLEEP_DURATION_RST;
    logic        cf_is_slave       = 1'b1;
    logic        cf_has_identity   = 1'b0;
    logic [9:0]  cf_beacon_int     = BEACON_INT_RST;
    logic [9:0]  cf_addr_retry     = ADDR_RETRY_RST;

    mode_t       lm_mode       = MODE_RUNNING;
    mode_t       lm_saved_mode = MODE_RUNNING;
    logic [7:0]  lm_dim        = 8'd255;
    logic [7:0]  lm_saved_dim  = 8'd255;
    logic        lm_run        = 1'b0;
    logic [31:0] lm_sleep_cnt  = '0;
    logic [31:0] lm_sleep_step = '0;
    logic [15:0] lm_idle_cnt   = '0;
    logic [9:0]  lm_addr_phase = 10'd1;   // slave out of reset: request pending
    logic [9:0]  lm_beacon_cnt = '0;

    // Bookkeeping shared between the processes
    lamp_cmd_t    cmd_backlog[$];   // beats waiting for the driver
    lamp_status_t status_due[$];    // predicted results, oldest first
    logic cmd_taken = 1'b0;         // driver's beat went in at the last rising edge
    logic hold_req  = 1'b0;         // ask the receiver for one long hold-off
    int   idle_pct  = 0;            // chance of starting an idle burst, per decision
    int   ok_pct    = 50;           // chance that a tick finds the radio free
    int   queued    = 0;
    int   fails     = 0;
    int   send_gap  = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    int   quiet_cycles = 0;

    // Apply one command beat to the shadow state; returns what the block
    // should report for it.
    function automatic lamp_status_t lamp_status_after(input lamp_cmd_t c);
        lamp_status_t s;
        logic [9:0]   prior;
        logic         in_sb_group;
        s.kind = SEND_NONE;
        s.clr  = 1'b0;
        in_sb_group = (lm_mode == MODE_ENTER_STANDBY) || (lm_mode == MODE_STANDBY) ||
                      (lm_mode == MODE_LEAVE_STANDBY);
        case (c.cmd)
            CMD_TICK: begin
                case (lm_mode)
                    MODE_RUNNING: lm_run = 1'b1;
                    MODE_PAUSE:   lm_run = 1'b0;
                    MODE_ENTER_STANDBY: begin
                        lm_saved_dim = lm_dim;
                        lm_dim       = '0;
                        lm_run       = 1'b0;
                        lm_mode      = MODE_STANDBY;
                    end
                    MODE_LEAVE_STANDBY: begin
                        lm_dim  = lm_saved_dim;
                        lm_run  = 1'b1;
                        lm_mode = lm_saved_mode;
                    end
                    MODE_ENTER_SLEEP: begin
                        lm_sleep_cnt = '0;
                        lm_saved_dim = lm_dim;
                        if (lm_dim == 8'd0) begin
                            // nothing to fade: straight to standby
                            lm_mode = MODE_STANDBY;
                            lm_run  = 1'b0;
                        end
                        else begin
                            lm_sleep_step = cf_sleep_duration / {24'd0, lm_dim};
                            if (lm_sleep_step == 32'd0)
                                lm_sleep_step = 32'd1;
                            lm_mode = MODE_SLEEP;
                        end
                    end
                    MODE_SLEEP: begin
                        lm_sleep_cnt = lm_sleep_cnt + 32'd1;
                        if (lm_sleep_cnt >= lm_sleep_step) begin
                            lm_sleep_cnt = '0;
                            if (lm_dim != 8'd0)
                                lm_dim = lm_dim - 8'd1;
                            if (lm_dim == 8'd0) begin
                                lm_mode = MODE_STANDBY;
                                lm_run  = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
                if (cf_is_slave) begin
                    if (lm_addr_phase == 10'd0) begin
                        prior = lm_beacon_cnt;
                        if (lm_beacon_cnt < CNT10_MAX)
                            lm_beacon_cnt = lm_beacon_cnt + 10'd1;
                        if (prior >= cf_beacon_int && c.ok) begin
                            s.kind        = SEND_BEACON;
                            lm_beacon_cnt = '0;
                        end
                    end
                    if (lm_addr_phase == 10'd1) begin
                        s.clr = 1'b1;
                        if (c.ok) begin
                            if (cf_has_identity)
                                s.kind = SEND_ANNOUNCE;
                            else
                                s.kind = SEND_QUERY;
                            lm_addr_phase = 10'd2;
                        end
                    end
                    // retry wait; also runs on the tick the request went out
                    if (lm_addr_phase > 10'd1) begin
                        prior = lm_addr_phase;
                        if (lm_addr_phase < CNT10_MAX)
                            lm_addr_phase = lm_addr_phase + 10'd1;
                        if (prior > cf_addr_retry || prior == CNT10_MAX)
                            lm_addr_phase = 10'd1;
                    end
                end
                if (lm_idle_cnt != 16'd0) begin
                    lm_idle_cnt = lm_idle_cnt - 16'd1;
                    if (lm_idle_cnt == 16'd0)
                        lm_mode = MODE_RUNNING;
                end
            end
            CMD_TOUCH: begin
                lm_idle_cnt = cf_idle_timeout;
                lm_mode     = MODE_PAUSE;
            end
            CMD_STANDBY: begin
                if (!in_sb_group) begin
                    lm_saved_mode = lm_mode;
                    lm_mode       = MODE_ENTER_STANDBY;
                end
            end
            CMD_LEAVE_STANDBY: begin
                if (lm_mode == MODE_STANDBY)
                    lm_mode = MODE_LEAVE_STANDBY;
            end
            CMD_SLEEP: begin
                if (!in_sb_group)
                    lm_mode = MODE_ENTER_SLEEP;
            end
            CMD_ADDR_ASSIGNED: lm_addr_phase = '0;
            CMD_SET_DIM:       lm_dim = c.dim;
            default: ;   // code seven does nothing
        endcase
        s.mode = lm_mode;
        s.run  = lm_run;
        s.dim  = lm_dim;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: takes beats off the backlog at the falling edge.
    // valid is only ever assigned once per edge.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        logic      v;
        lamp_cmd_t nb;
        v = in_valid;
        if (cmd_taken) begin
            cmd_taken = 1'b0;
            v = 1'b0;
        end
        if (!v && rst_n) begin
            if (send_gap > 0)
                send_gap--;
            else if (cmd_backlog.size() > 0) begin
                if ($urandom_range(0, 99) < idle_pct)
                    send_gap = $urandom_range(0, 16);   // start an idle burst
                else begin
                    nb = cmd_backlog.pop_front();
                    command   <= nb.cmd;
                    dim_value <= nb.dim;
                    send_ok   <= nb.ok;
                    v = 1'b1;
                end
            end
        end
        in_valid <= v;
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus the one long hold-off
    // that lets the block fill up and push back on the command side.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        logic r;
        r = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end
        else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            r = 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            r = 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 16);
            r = 1'b0;
        end
        out_ready <= r;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. The result side is
    // checked before the new command's prediction goes in; a result can
    // never belong to a beat taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        lamp_status_t got;
        lamp_status_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.mode = mode_t'(mode_code);
                got.run  = running;
                got.dim  = dim_level;
                got.kind = send_t'(send_kind);
                got.clr  = address_clear;
                if (status_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: mode %0d run %0b dim %0d send %0d clr %0b",
                                 got.mode, got.run, got.dim, got.kind, got.clr);
                end
                else begin
                    want = status_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result mismatch: want mode %0d run %0b dim %0d send %0d ",
                                      "clr %0b, got mode %0d run %0b dim %0d send %0d clr %0b"},
                                     want.mode, want.run, want.dim, want.kind, want.clr,
                                     got.mode, got.run, got.dim, got.kind, got.clr);
                    end
                end
            end
            if (in_valid && in_ready) begin
                status_due.push_back(lamp_status_after('{command, dim_value, send_ok}));
                cmd_taken = 1'b1;
            end
        end
    end

    // Watchdog: too long without a beat on any channel means a hang
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lamp_mode_sleep_fade_controller_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [2:0] c, input logic [7:0] d, input logic o);
        cmd_backlog.push_back('{c, d, o});
        queued++;
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            queue_beat(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 99) < ok_pct));
    endtask

    // Any code at all, with random fields; address assignment is held back
    // while the request/retry side is still under test.
    task automatic queue_noise(input bit with_addr);
        logic [2:0] c;
        c = 3'($urandom_range(0, 7));
        if (!with_addr && c == CMD_ADDR_ASSIGNED)
            c = CMD_TICK;
        queue_beat(c, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Mostly ticks with a sprinkle of noise: keeps the slave counters
    // climbing through several intervals.
    task automatic queue_tick_run(input int n, input bit with_addr);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_noise(with_addr);
            else
                queue_ticks(1);
        end
    endtask

    // Well-formed sequences (fades, standby round trips, touch timeouts)
    // with random content, plus some noise.
    task automatic queue_mixed_run(input int n, input bit with_addr);
        int start;
        start = queued;
        while (queued - start < n) begin
            case ($urandom_range(0, 6))
                0: queue_ticks($urandom_range(1, 40));
                1: begin
                    // fade from a low level mostly, so it completes
                    if ($urandom_range(0, 3) == 0)
                        queue_beat(CMD_SET_DIM, 8'($urandom), 1'($urandom_range(0, 1)));
                    else
                        queue_beat(CMD_SET_DIM, 8'($urandom_range(0, 6)),
                                   1'($urandom_range(0, 1)));
                    queue_beat(CMD_SLEEP, 8'($urandom), 1'($urandom_range(0, 1)));
                    queue_ticks($urandom_range(1, 60));
                end
                2: begin
                    queue_beat(CMD_STANDBY, 8'($urandom), 1'($urandom_range(0, 1)));
                    queue_ticks($urandom_range(1, 3));
                    if ($urandom_range(0, 1))
                        queue_noise(with_addr);
                    queue_beat(CMD_LEAVE_STANDBY, 8'($urandom), 1'($urandom_range(0, 1)));
                    queue_ticks($urandom_range(1, 3));
                end
                3: begin
                    queue_beat(CMD_TOUCH, 8'($urandom), 1'($urandom_range(0, 1)));
                    queue_ticks($urandom_range(1, 12));
                end
                4: queue_noise(with_addr);
                default: queue_beat(CMD_SET_DIM, 8'($urandom), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // Register write, one beat; the shadow copy follows once it is taken
    task automatic set_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_IDLE_TIMEOUT:   cf_idle_timeout   = val[15:0];
            CFG_SLEEP_DURATION: cf_sleep_duration = val;
            CFG_IS_SLAVE:       cf_is_slave       = val[0];
            CFG_HAS_IDENTITY:   cf_has_identity   = val[0];
            CFG_BEACON_INT:     cf_beacon_int     = val[9:0];
            CFG_ADDR_RETRY:     cf_addr_retry     = val[9:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued beat is in and every result is out
    task automatic drain();
        @(posedge clk);
        while (cmd_backlog.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: short timeout and fade so each corner shows up quickly.
        set_reg(CFG_IDLE_TIMEOUT, 32'd2);
        set_reg(CFG_SLEEP_DURATION, 32'd5);
        set_reg(CFG_IS_SLAVE, 32'd1);
        set_reg(CFG_HAS_IDENTITY, 32'd0);
        set_reg(CFG_BEACON_INT, 32'd2);
        set_reg(CFG_ADDR_RETRY, 32'd3);
        idle_pct = 10;
        queue_beat(CMD_TICK, 8'h00, 1'b0);          // radio busy: address cleared, no send
        queue_beat(CMD_TICK, 8'hFF, 1'b1);          // query goes out
        queue_beat(CMD_LEAVE_STANDBY, 8'h00, 1'b0); // not in standby: ignored
        queue_beat(CMD_SET_DIM, 8'hFF, 1'b0);
        queue_beat(3'd7, 8'hAA, 1'b1);              // unused code
        queue_beat(CMD_TOUCH, 8'h55, 1'b0);
        queue_beat(CMD_TICK, 8'h00, 1'b0);
        queue_beat(CMD_TICK, 8'h00, 1'b0);          // timeout runs out: back to running
        queue_beat(CMD_STANDBY, 8'h00, 1'b0);
        queue_beat(CMD_STANDBY, 8'h00, 1'b0);       // already entering: ignored
        queue_beat(CMD_SLEEP, 8'h00, 1'b0);         // standby group: ignored
        queue_beat(CMD_TICK, 8'h00, 1'b1);
        queue_beat(CMD_LEAVE_STANDBY, 8'h00, 1'b0);
        queue_beat(CMD_TICK, 8'h00, 1'b0);          // dim and mode restored
        queue_beat(CMD_SET_DIM, 8'h00, 1'b1);
        queue_beat(CMD_SLEEP, 8'h00, 1'b0);
        queue_beat(CMD_TICK, 8'h00, 1'b0);          // zero dim: standby at once
        queue_beat(CMD_LEAVE_STANDBY, 8'h00, 1'b0);
        queue_beat(CMD_TICK, 8'h00, 1'b1);
        queue_beat(CMD_SET_DIM, 8'h07, 1'b0);
        queue_beat(CMD_SLEEP, 8'h00, 1'b0);
        queue_beat(CMD_TICK, 8'h00, 1'b0);          // 5/7 rounds to zero: step clamped
        queue_beat(CMD_TICK, 8'h00, 1'b0);
        queue_beat(CMD_SET_DIM, 8'h00, 1'b0);       // dim gone mid-fade
        queue_beat(CMD_TICK, 8'h00, 1'b0);          // no wrap, standby
        drain();

        // Address request side first: once an address is assigned the
        // request phase never comes back.
        set_reg(CFG_IDLE_TIMEOUT, 32'd5);
        set_reg(CFG_SLEEP_DURATION, 32'd40);
        set_reg(CFG_HAS_IDENTITY, 32'd1);
        set_reg(CFG_ADDR_RETRY, 32'd1);
        idle_pct = 15;
        ok_pct   = 70;
        queue_mixed_run(90, 1'b0);
        drain();

        // Slave side off, extreme short settings
        set_reg(CFG_IDLE_TIMEOUT, 32'd0);
        set_reg(CFG_SLEEP_DURATION, 32'd1);
        set_reg(CFG_IS_SLAVE, 32'd0);
        set_reg(CFG_HAS_IDENTITY, 32'd0);
        idle_pct = 25;
        queue_mixed_run(90, 1'b0);
        drain();

        // Retry counter with long waits between requests
        set_reg(CFG_IDLE_TIMEOUT, 32'd30);
        set_reg(CFG_SLEEP_DURATION, 32'd20);
        set_reg(CFG_IS_SLAVE, 32'd1);
        set_reg(CFG_ADDR_RETRY, 32'd60);
        idle_pct = 5;
        ok_pct   = 90;
        queue_tick_run(150, 1'b0);
        drain();

        // Address held; widest timeout and fade, beacon interval of 1.
        // The receiver holds off for a long stretch at the start.
        set_reg(CFG_IDLE_TIMEOUT, 32'd65535);
        set_reg(CFG_SLEEP_DURATION, 32'hFFFF_FFFF);
        set_reg(CFG_HAS_IDENTITY, 32'd1);
        set_reg(CFG_BEACON_INT, 32'd1);
        idle_pct = 12;
        ok_pct   = 60;
        queue_beat(CMD_ADDR_ASSIGNED, 8'($urandom), 1'($urandom_range(0, 1)));
        queue_mixed_run(90, 1'b1);
        @(posedge clk);
        hold_req = 1'b1;
        drain();

        // Beacon counter with a longer interval, radio mostly busy
        set_reg(CFG_IDLE_TIMEOUT, 32'd10);
        set_reg(CFG_SLEEP_DURATION, 32'd100);
        set_reg(CFG_BEACON_INT, 32'd40);
        idle_pct = 5;
        ok_pct   = 30;
        queue_tick_run(150, 1'b1);
        drain();

        // Random settings, then a last stretch with no idling at all
        for (int ph = 0; ph < 2; ph++) begin
            set_reg(CFG_IDLE_TIMEOUT, $urandom_range(0, 40));
            set_reg(CFG_SLEEP_DURATION, $urandom_range(1, 600));
            set_reg(CFG_IS_SLAVE, $urandom_range(0, 1));
            set_reg(CFG_HAS_IDENTITY, $urandom_range(0, 1));
            set_reg(CFG_BEACON_INT, $urandom_range(1, 20));
            set_reg(CFG_ADDR_RETRY, $urandom_range(1, 20));
            idle_pct = (ph == 0) ? 15 : 0;
            ok_pct   = $urandom_range(20, 90);
            queue_mixed_run(90, 1'b1);
            drain();
        end

        // drain() already waited out the slowest beat; allow a little more
        // for any stray result to show up.
        repeat (40) @(posedge clk);
        if (fails == 0 && status_due.size() == 0)
            $display("lamp_mode_sleep_fade_controller_test: done, clean");
        else
            $display("lamp_mode_sleep_fade_controller_test: done, errors");
        $finish;
    end

endmodule
